@@ rtl/srw_pkg.sv @@
package srw_pkg;

	localparam int SEQ_W = 32;
	localparam int TOK_W = 16;
	localparam int ST_W  = 3;
	localparam int OP_W  = 2;

	// result buffer for tokens released by one step
	localparam int MAX_RESULTS = 16;
	localparam int BUF_AW      = 4;
	localparam int BUF_CW      = 5;

	localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
	localparam logic [OP_W-1:0] OP_DEFER   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_SEEN     = 3'd1;
	localparam logic [ST_W-1:0] ST_COLLIDE  = 3'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_CNT,
		S_EVAL,
		S_REL,
		S_RDNEXT,
		S_CHK,
		S_MATCH,
		S_COUNT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic match;
		logic count;
		logic eval;
		logic rel;
		logic rd_next;
		logic step_next;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic advance;
		logic rem_zero;
		logic at_max;
		logic next_marked;
		logic out_last;
	} sts_t;

endpackage

@@ rtl/srw_ram.sv @@
module srw_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/srw_ctrl.sv @@
module srw_ctrl import srw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic cfg_we,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic result_valid
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (sts.clr_done) state_d = S_IDLE;
			S_IDLE:   if (start) state_d = S_LOOK;
			S_LOOK:   state_d = S_CNT;
			S_CNT:    state_d = S_EVAL;
			S_EVAL:   state_d = sts.advance ? S_REL : S_OUT;
			S_REL: begin
				if (sts.rem_zero) begin
					state_d = sts.at_max ? S_OUT : S_RDNEXT;
				end
			end
			S_RDNEXT: state_d = S_CHK;
			S_CHK:    state_d = sts.next_marked ? S_MATCH : S_OUT;
			S_MATCH:  state_d = S_COUNT;
			S_COUNT:  state_d = S_REL;
			S_OUT:    if (sts.out_last) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
		// a register write restarts the clearing sweep
		if (cfg_we) begin
			state_d = S_CLEAR;
		end
	end

	// commands to the datapath
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		result_valid = 1'b0;
		case (state_q)
			S_CLEAR:  cmd.clr_step = 1'b1;
			S_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			S_LOOK:   cmd.match = 1'b1;
			S_CNT:    cmd.count = 1'b1;
			S_EVAL:   cmd.eval = 1'b1;
			S_REL:    cmd.rel = !sts.rem_zero;
			S_RDNEXT: cmd.rd_next = 1'b1;
			S_CHK:    cmd.step_next = sts.next_marked;
			S_MATCH:  cmd.match = 1'b1;
			S_COUNT:  cmd.count = 1'b1;
			S_OUT: begin
				cmd.emit = 1'b1;
				result_valid = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/srw_dp.sv @@
module srw_dp import srw_pkg::*; #(
	parameter int WINDOW_DEPTH  = 64,
	parameter int PENDING_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [SEQ_W-1:0] cfg_data,
	input  logic [OP_W-1:0]  op,
	input  logic [SEQ_W-1:0] sequence_req,
	input  logic [TOK_W-1:0] token,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic [ST_W-1:0]  status,
	output logic             hit,
	output logic [SEQ_W-1:0] prefix,
	output logic [TOK_W-1:0] released_token,
	output logic             token_valid,
	output logic             last
);

	localparam int AW      = $clog2(WINDOW_DEPTH);
	localparam int CLR_LEN = (WINDOW_DEPTH > 32) ? WINDOW_DEPTH : 32;
	localparam int CLRW    = $clog2(CLR_LEN);
	localparam int CW      = $clog2(PENDING_DEPTH + 1);
	localparam int PIW     = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int RW      = SEQ_W + 1;
	// reciprocal of the ring depth, exact floor quotient for any 32-bit value
	localparam int          RK    = SEQ_W + AW;
	localparam int          MW    = SEQ_W + 2;
	localparam int          PW    = 2 * SEQ_W + 2;
	localparam logic [63:0] RECIP = ((64'd1 << RK) / 64'(WINDOW_DEPTH)) + 64'd1;

	logic [SEQ_W-1:0] sv_q, prefix_q, seq_q, quo_q;
	logic [AW-1:0]    pslot_q, slot_q;
	logic [CLRW-1:0]  clr_q;
	logic [OP_W-1:0]  op_q;
	logic [TOK_W-1:0] tok_q;
	logic [PENDING_DEPTH-1:0] match_q, wvalid_q;
	logic [SEQ_W-1:0] wseq_q    [PENDING_DEPTH];
	logic [TOK_W-1:0] whandle_q [PENDING_DEPTH];
	logic [CW-1:0]    wstamp_q  [PENDING_DEPTH];
	logic [CW-1:0]    rem_q;
	logic [TOK_W-1:0] buf_q [MAX_RESULTS];
	logic [BUF_CW-1:0] bcnt_q;
	logic [BUF_AW-1:0] oi_q;
	logic [ST_W-1:0]  st_q;
	logic             hit_q, stv_q;
	logic [TOK_W-1:0] stok_q;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [RW-1:0]    ram_wdata, ram_rdata;

	// slot of the next sequence after the prefix
	logic [AW-1:0] nslot;
	assign nslot = (pslot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : pslot_q + AW'(1);

	// slot of an incoming sequence, valid when it lies inside the window
	logic [SEQ_W-1:0] acc_diff;
	logic [AW:0]      acc_sum, acc_slot;
	always_comb begin
		acc_diff = sequence_req - prefix_q;
		acc_sum  = {1'b0, pslot_q} + acc_diff[AW:0];
		acc_slot = (acc_sum >= (AW+1)'(WINDOW_DEPTH)) ?
			acc_sum - (AW+1)'(WINDOW_DEPTH) : acc_sum;
	end

	// reduce the start value modulo the ring depth during the sweep:
	// reciprocal multiply for the quotient, then multiply back and subtract
	logic          clr_in_ram;
	logic [PW-1:0] quo_prod;
	logic [SEQ_W-1:0] start_rem;
	always_comb begin
		clr_in_ram = (CLRW+1)'(clr_q) < (CLRW+1)'(WINDOW_DEPTH);
		quo_prod   = PW'(sv_q) * PW'(RECIP[MW-1:0]);
		start_rem  = sv_q - quo_q * SEQ_W'(WINDOW_DEPTH);
	end

	// decision for the accepted item
	logic             le, ovf, nxt, rflag, rmatch, full, e_mark, e_store, e_adv;
	logic [SEQ_W-1:0] diff, rnum, pnext;
	logic [ST_W-1:0]  e_st;
	logic             e_hit, e_tv;
	always_comb begin
		pnext  = prefix_q + SEQ_W'(1);
		le     = seq_q <= prefix_q;
		diff   = seq_q - prefix_q;
		ovf    = diff > SEQ_W'(WINDOW_DEPTH);
		nxt    = seq_q == pnext;
		rflag  = ram_rdata[SEQ_W];
		rnum   = ram_rdata[SEQ_W-1:0];
		rmatch = rflag && (rnum == seq_q);
		full   = &wvalid_q;
		e_st   = ST_OK;
		e_hit  = 1'b0;
		e_tv   = 1'b0;
		e_mark = 1'b0;
		e_store = 1'b0;
		e_adv  = 1'b0;
		case (op_q)
			OP_OBSERVE: begin
				if (le) begin
					e_st = ST_SEEN;
				end else if (ovf) begin
					e_st = ST_OVERFLOW;
				end else if (nxt) begin
					e_adv = 1'b1;
				end else if (rflag) begin
					e_st = rmatch ? ST_SEEN : ST_COLLIDE;
				end else begin
					e_mark = 1'b1;
				end
			end
			OP_DEFER: begin
				if (le) begin
					e_tv = 1'b1;
				end else if (ovf) begin
					e_st = ST_OVERFLOW;
				end else if (full) begin
					e_st = ST_FULL;
				end else begin
					e_store = 1'b1;
				end
			end
			OP_QUERY: e_hit = le || (!ovf && rmatch);
			default: ;
		endcase
	end

	// lowest free waiter entry
	logic [PIW-1:0] free_idx;
	always_comb begin
		free_idx = '0;
		for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
			if (!wvalid_q[i]) free_idx = PIW'(i);
		end
	end

	// waiter of the current sequence with the highest remaining rank
	logic           rel_found;
	logic [PIW-1:0] rel_idx;
	logic [CW-1:0]  tgt;
	always_comb begin
		rel_found = 1'b0;
		rel_idx   = '0;
		tgt       = rem_q - CW'(1);
		for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
			if (match_q[i] && (wstamp_q[i] == tgt)) begin
				rel_found = 1'b1;
				rel_idx   = PIW'(i);
			end
		end
	end

	// window ring memory: clear sweep, mark, consume
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = nslot;
		ram_wdata = '0;
		if (cmd.clr_step && clr_in_ram) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q[AW-1:0];
		end else if (cmd.eval && e_mark) begin
			ram_we    = 1'b1;
			ram_waddr = slot_q;
			ram_wdata = {1'b1, seq_q};
		end else if (cmd.step_next) begin
			ram_we    = 1'b1;
		end
		ram_re    = cmd.load || cmd.rd_next;
		ram_raddr = cmd.load ? acc_slot[AW-1:0] : nslot;
	end

	srw_ram #(.WIDTH(RW), .DEPTH(WINDOW_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state: prefix, sweep, waiter valid bits, buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q     <= '0;
			prefix_q <= '0;
			pslot_q  <= '0;
			quo_q    <= '0;
			clr_q    <= '0;
			wvalid_q <= '0;
			bcnt_q   <= '0;
			oi_q     <= '0;
			rem_q    <= '0;
		end else if (cfg_we) begin
			sv_q     <= cfg_data;
			prefix_q <= cfg_data;
			pslot_q  <= '0;
			clr_q    <= '0;
			wvalid_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + CLRW'(1);
				if (clr_q == '0) quo_q <= SEQ_W'(quo_prod >> RK);
				if (clr_q == CLRW'(1)) pslot_q <= start_rem[AW-1:0];
			end
			if (cmd.load) begin
				bcnt_q <= '0;
				oi_q   <= '0;
			end
			if (cmd.count) rem_q <= CW'($countones(match_q));
			if (cmd.eval && e_adv) begin
				prefix_q <= seq_q;
				pslot_q  <= nslot;
			end
			if (cmd.eval && e_store) wvalid_q[free_idx] <= 1'b1;
			if (cmd.step_next) begin
				prefix_q <= pnext;
				pslot_q  <= nslot;
			end
			if (cmd.rel) begin
				rem_q <= rem_q - CW'(1);
				if (rel_found) begin
					wvalid_q[rel_idx] <= 1'b0;
					if (bcnt_q < BUF_CW'(MAX_RESULTS)) bcnt_q <= bcnt_q + BUF_CW'(1);
				end
			end
			if (cmd.emit) oi_q <= oi_q + BUF_AW'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			seq_q  <= sequence_req;
			tok_q  <= token;
			slot_q <= acc_slot[AW-1:0];
		end
		if (cmd.match) begin
			for (int i = 0; i < PENDING_DEPTH; i++) begin
				match_q[i] <= wvalid_q[i] && (wseq_q[i] == seq_q);
			end
		end
		if (cmd.eval) begin
			st_q   <= e_st;
			hit_q  <= e_hit;
			stv_q  <= e_tv;
			stok_q <= e_tv ? tok_q : '0;
			if (e_store) begin
				wseq_q[free_idx]    <= seq_q;
				whandle_q[free_idx] <= tok_q;
				wstamp_q[free_idx]  <= rem_q;
			end
		end
		if (cmd.step_next) seq_q <= pnext;
		if (cmd.rel && rel_found) begin
			match_q[rel_idx] <= 1'b0;
			if (bcnt_q < BUF_CW'(MAX_RESULTS)) buf_q[bcnt_q[BUF_AW-1:0]] <= whandle_q[rel_idx];
		end
	end

	// status to the controller
	assign sts.clr_done    = clr_q == CLRW'(CLR_LEN - 1);
	assign sts.advance     = e_adv;
	assign sts.rem_zero    = rem_q == '0;
	assign sts.at_max      = &prefix_q;
	assign sts.next_marked = rflag && (rnum == pnext);
	assign sts.out_last    = (bcnt_q == '0) ? (oi_q == '0) :
		({1'b0, oi_q} == bcnt_q - BUF_CW'(1));

	// result fields: released tokens when any, else the single result
	assign status         = (bcnt_q != '0) ? ST_OK : st_q;
	assign hit            = (bcnt_q != '0) ? 1'b0 : hit_q;
	assign released_token = (bcnt_q != '0) ? buf_q[oi_q] : stok_q;
	assign token_valid    = (bcnt_q != '0) ? 1'b1 : stv_q;
	assign prefix         = prefix_q;
	assign last           = sts.out_last;

endmodule

@@ rtl/sequence_reorder_window_top.sv @@
// Flow: an accepted item is looked up, counted and evaluated; an advance releases the waiters
//   of the new prefix, then, unless the prefix reaches its maximum, walks the ring through each
//   further marked sequence and releases its waiters before the results are emitted.
// Throughput: one item at a time; results leave one per cycle, 1 to 16 per item.
// Reset and each start_sequence write run a ring clearing sweep with busy high;
//   the receiver cannot stall and takes every strobed result.
module sequence_reorder_window_top import srw_pkg::*; #(
	parameter int WINDOW_DEPTH  = 64,
	parameter int PENDING_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SEQ_W-1:0] cfg_data,
	input  logic [OP_W-1:0]  op,
	input  logic [SEQ_W-1:0] sequence_req,
	input  logic [TOK_W-1:0] token,
	output logic             result_valid,
	output logic [ST_W-1:0]  status,
	output logic             hit,
	output logic [SEQ_W-1:0] prefix,
	output logic [TOK_W-1:0] released_token,
	output logic             token_valid,
	output logic             last
);

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	srw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cfg_we       (cfg_we),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	srw_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .PENDING_DEPTH(PENDING_DEPTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.op             (op),
		.sequence_req   (sequence_req),
		.token          (token),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.hit            (hit),
		.prefix         (prefix),
		.released_token (released_token),
		.token_valid    (token_valid),
		.last           (last)
	);

`ifndef SYNTHESIS
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result strobe outside a busy step");
	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_we) |=> (busy && !result_valid))
		else $error("accepted item did not start a step");
	a_last_ends_step: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last && !cfg_we) |=> (!busy && !result_valid))
		else $error("step continued after its last result");
`endif

endmodule
